/* rtl/ceq_pkg.sv */
// Shared types and constants for the coalescing event queue.
// Holds command, result and sequencer state encodings; depends on nothing.
package ceq_pkg;

    // Width of the register-bus byte address.
    localparam int PADDR_W = 3;

    // Register index of the enable register (paddr bit 2 selects the register).
    localparam logic CFG_ENABLE = 1'b0;

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_NOTIFY     = 2'd2,
        CMD_POP        = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        RC_OK          = 3'd0,
        RC_INVALID     = 3'd1,
        RC_NOT_ENABLED = 3'd2,
        RC_DUP_FULL    = 3'd3,
        RC_NOT_FOUND   = 3'd4,
        RC_EMPTY       = 3'd5
    } t_rc;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_UNL_RD,
        S_PRED,
        S_PRED_END,
        S_COMMIT,
        S_POP_RD,
        S_POP_WB,
        S_DONE
    } t_state;

endpackage

/* rtl/coalescing_event_queue.sv */
// Coalescing event queue: slot table, pending FIFO kept as a linked list, status counters.
// Depends on ceq_pkg for command, result code and sequencer state encodings.
//
//  Channel   | Handshake                         | Payload
//  ----------+-----------------------------------+------------------------------------------
//  command   | start in, busy out                | i_cmd, i_node_id, i_token
//  result    | o_done strobe, one cycle          | o_result_code, o_token_out, counters
//  register  | psel/penable/pwrite, pready = 1   | paddr, pwdata, prdata (enable at 0x0)
//
// An item is taken at a clock edge where start is high and busy is low. Register and notify
// scan the slot memories one slot per cycle through a single read port before their result
// strobe is shown. Unregistering a queued slot needs a second scan to find its predecessor in
// the FIFO. A pop reads the head slot and then unlinks it; a command refused at acceptance
// goes straight to its result. busy falls in the cycle the strobe is shown, so the next item
// may be taken right then. The result strobe cannot be stalled.
// Reset is synchronous and active low; it frees all slots through per-slot occupancy flops,
// so no clearing pass runs and the block takes items right after reset.
module coalescing_event_queue #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Command channel.
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_cmd,
    input  logic [15:0]                 i_node_id,
    input  logic [31:0]                 i_token,
    // Result channel.
    output logic                        o_done,
    output logic [2:0]                  o_result_code,
    output logic [31:0]                 o_token_out,
    output logic [4:0]                  o_registered_count,
    output logic [4:0]                  o_pending_count,
    output logic [4:0]                  o_max_pending,
    output logic [31:0]                 o_coalesced_count,
    output logic [31:0]                 o_delivered_count,
    // Register port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ceq_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ceq_pkg::*;

    // Slot index width and width of counts that can reach SLOT_COUNT itself.
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

    // Sequencer and control state.
    t_state r_state, n_state;
    logic   r_enable, n_enable;
    logic   r_cmp_vld, n_cmp_vld;
    logic   r_done, n_done;

    // Slot flags: occupancy stands in for "node is nonzero", so a slot that was never written
    // reads as free without any clearing of the memories.
    logic [SLOT_COUNT-1:0] r_occ, n_occ;
    logic [SLOT_COUNT-1:0] r_pend, n_pend;

    // FIFO pointers and counters.
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_reg_cnt, n_reg_cnt;
    logic [CW-1:0] r_pend_cnt, n_pend_cnt;
    logic [CW-1:0] r_peak, n_peak;
    logic [31:0]   r_coal, n_coal;
    logic [31:0]   r_deliv, n_deliv;

    // Latched command and scan bookkeeping.
    t_cmd          r_cmd, n_cmd;
    logic [15:0]   r_node, n_node;
    logic [31:0]   r_tok, n_tok;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_cmp_idx, n_cmp_idx;
    logic          r_dup, n_dup;
    logic          r_free_found, n_free_found;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic          r_hit, n_hit;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic          r_pred_found, n_pred_found;
    logic [IW-1:0] r_pred_idx, n_pred_idx;
    logic [IW-1:0] r_succ, n_succ;
    t_rc           r_code, n_code;
    logic [31:0]   r_tok_out, n_tok_out;

    // Result registers.
    t_rc         r_res_code, n_res_code;
    logic [31:0] r_res_tok, n_res_tok;
    logic [4:0]  r_res_reg, n_res_reg;
    logic [4:0]  r_res_pend, n_res_pend;
    logic [4:0]  r_res_peak, n_res_peak;
    logic [31:0] r_res_coal, n_res_coal;
    logic [31:0] r_res_deliv, n_res_deliv;

    // Slot memories with one shared read address and registered read data.
    logic [15:0]   r_node_mem [SLOT_COUNT];
    logic [31:0]   r_tok_mem  [SLOT_COUNT];
    logic [IW-1:0] r_next_mem [SLOT_COUNT];
    logic [15:0]   r_node_q;
    logic [31:0]   r_tok_q;
    logic [IW-1:0] r_next_q;

    logic [IW-1:0] rd_addr;
    logic          slot_we;
    logic [IW-1:0] slot_wa;
    logic          next_we;
    logic [IW-1:0] next_wa;
    logic [IW-1:0] next_wd;

    t_cmd cmd_in;
    logic cfg_wr;

    assign cmd_in = t_cmd'(i_cmd);
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        n_state      = r_state;
        n_enable     = r_enable;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_idx;
        n_done       = 1'b0;
        n_occ        = r_occ;
        n_pend       = r_pend;
        n_head       = r_head;
        n_tail       = r_tail;
        n_reg_cnt    = r_reg_cnt;
        n_pend_cnt   = r_pend_cnt;
        n_peak       = r_peak;
        n_coal       = r_coal;
        n_deliv      = r_deliv;
        n_cmd        = r_cmd;
        n_node       = r_node;
        n_tok        = r_tok;
        n_idx        = r_idx;
        n_dup        = r_dup;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_pred_found = r_pred_found;
        n_pred_idx   = r_pred_idx;
        n_succ       = r_succ;
        n_code       = r_code;
        n_tok_out    = r_tok_out;
        n_res_code   = r_res_code;
        n_res_tok    = r_res_tok;
        n_res_reg    = r_res_reg;
        n_res_pend   = r_res_pend;
        n_res_peak   = r_res_peak;
        n_res_coal   = r_res_coal;
        n_res_deliv  = r_res_deliv;
        rd_addr      = r_idx;
        slot_we      = 1'b0;
        slot_wa      = r_free_idx;
        next_we      = 1'b0;
        next_wa      = r_tail;
        next_wd      = r_cmp_idx;

        if (cfg_wr && paddr[PADDR_W-1] == CFG_ENABLE) begin
            n_enable = pwdata[0];
        end

        // Compare stage: works on the slot whose read was issued in the previous cycle.
        if (r_cmp_vld) begin
            if (r_state == S_PRED || r_state == S_PRED_END) begin
                // The predecessor is the queued slot, other than the tail, that links to the victim.
                if (r_pend[r_cmp_idx] && r_cmp_idx != r_tail && r_next_q == r_hit_idx) begin
                    n_pred_found = 1'b1;
                    n_pred_idx   = r_cmp_idx;
                end
            end else begin
                case (r_cmd)
                    CMD_REGISTER: begin
                        if (r_occ[r_cmp_idx] && r_tok_q == r_tok) begin
                            n_dup = 1'b1;
                        end
                        if (!r_occ[r_cmp_idx] && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_cmp_idx;
                        end
                    end
                    CMD_UNREGISTER: begin
                        if (r_occ[r_cmp_idx] && r_node_q == r_node && r_tok_q == r_tok) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_cmp_idx;
                        end
                    end
                    CMD_NOTIFY: begin
                        if (r_occ[r_cmp_idx] && r_node_q == r_node) begin
                            if (r_pend[r_cmp_idx]) begin
                                n_coal = r_coal + 32'd1;
                            end else begin
                                n_pend[r_cmp_idx] = 1'b1;
                                if (r_pend_cnt != '0) begin
                                    next_we = 1'b1;
                                    next_wa = r_tail;
                                    next_wd = r_cmp_idx;
                                end else begin
                                    n_head = r_cmp_idx;
                                end
                                n_tail     = r_cmp_idx;
                                n_pend_cnt = r_pend_cnt + CW'(1);
                                if (n_pend_cnt > r_peak) begin
                                    n_peak = n_pend_cnt;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd        = cmd_in;
                    n_node       = i_node_id;
                    n_tok        = i_token;
                    n_idx        = '0;
                    n_dup        = 1'b0;
                    n_free_found = 1'b0;
                    n_hit        = 1'b0;
                    n_pred_found = 1'b0;
                    n_tok_out    = '0;
                    if (((cmd_in inside {CMD_REGISTER, CMD_UNREGISTER})
                            && (i_node_id == '0 || i_token == '0))
                            || (cmd_in == CMD_NOTIFY && i_node_id == '0)) begin
                        n_code  = RC_INVALID;
                        n_state = S_DONE;
                    end else if (!r_enable) begin
                        n_code  = RC_NOT_ENABLED;
                        n_state = S_DONE;
                    end else if (cmd_in == CMD_POP) begin
                        if (r_pend_cnt == '0) begin
                            n_code  = RC_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_addr   = r_idx;
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_SCAN_END: begin
                // Decisions include the compare of the last slot done in this cycle.
                case (r_cmd)
                    CMD_REGISTER: begin
                        if (n_dup || !n_free_found) begin
                            n_code  = RC_DUP_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_COMMIT;
                        end
                    end
                    CMD_UNREGISTER: begin
                        if (!n_hit) begin
                            n_code  = RC_NOT_FOUND;
                            n_state = S_DONE;
                        end else if (r_pend[n_hit_idx]) begin
                            n_state = S_UNL_RD;
                        end else begin
                            n_state = S_COMMIT;
                        end
                    end
                    default: begin
                        n_code  = RC_OK;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_UNL_RD: begin
                rd_addr = r_hit_idx;
                n_idx   = '0;
                n_state = S_PRED;
            end
            S_PRED: begin
                if (r_idx == '0) begin
                    n_succ = r_next_q;
                end
                rd_addr   = r_idx;
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = S_PRED_END;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_PRED_END: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_code  = RC_OK;
                n_state = S_DONE;
                case (r_cmd)
                    CMD_REGISTER: begin
                        slot_we            = 1'b1;
                        slot_wa            = r_free_idx;
                        n_occ[r_free_idx]  = 1'b1;
                        n_pend[r_free_idx] = 1'b0;
                        n_reg_cnt          = r_reg_cnt + CW'(1);
                    end
                    CMD_UNREGISTER: begin
                        n_occ[r_hit_idx] = 1'b0;
                        n_reg_cnt        = r_reg_cnt - CW'(1);
                        if (r_pend[r_hit_idx]) begin
                            n_pend[r_hit_idx] = 1'b0;
                            n_pend_cnt        = r_pend_cnt - CW'(1);
                            if (r_pred_found) begin
                                next_we = 1'b1;
                                next_wa = r_pred_idx;
                                next_wd = r_succ;
                            end else begin
                                n_head = r_succ;
                            end
                            if (r_tail == r_hit_idx) begin
                                n_tail = r_pred_found ? r_pred_idx : '0;
                            end
                            if (r_pend_cnt == CW'(1)) begin
                                n_head = '0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POP_RD: begin
                rd_addr = r_head;
                n_state = S_POP_WB;
            end
            S_POP_WB: begin
                n_tok_out      = r_tok_q;
                n_head         = (r_pend_cnt == CW'(1)) ? '0 : r_next_q;
                if (r_tail == r_head) begin
                    n_tail = '0;
                end
                n_pend[r_head] = 1'b0;
                n_pend_cnt     = r_pend_cnt - CW'(1);
                n_deliv        = r_deliv + 32'd1;
                n_code         = RC_OK;
                n_state        = S_DONE;
            end
            S_DONE: begin
                n_done      = 1'b1;
                n_res_code  = r_code;
                n_res_tok   = r_tok_out;
                n_res_reg   = 5'(r_reg_cnt);
                n_res_pend  = 5'(r_pend_cnt);
                n_res_peak  = 5'(r_peak);
                n_res_coal  = r_coal;
                n_res_deliv = r_deliv;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_enable   <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_done     <= 1'b0;
            r_occ      <= '0;
            r_pend     <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_reg_cnt  <= '0;
            r_pend_cnt <= '0;
            r_peak     <= '0;
            r_coal     <= '0;
            r_deliv    <= '0;
        end else begin
            r_state    <= n_state;
            r_enable   <= n_enable;
            r_cmp_vld  <= n_cmp_vld;
            r_done     <= n_done;
            r_occ      <= n_occ;
            r_pend     <= n_pend;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_reg_cnt  <= n_reg_cnt;
            r_pend_cnt <= n_pend_cnt;
            r_peak     <= n_peak;
            r_coal     <= n_coal;
            r_deliv    <= n_deliv;
        end
    end

    // Payload and scan bookkeeping; every use is qualified by control state.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_node       <= n_node;
        r_tok        <= n_tok;
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_dup        <= n_dup;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_pred_found <= n_pred_found;
        r_pred_idx   <= n_pred_idx;
        r_succ       <= n_succ;
        r_code       <= n_code;
        r_tok_out    <= n_tok_out;
        r_res_code   <= n_res_code;
        r_res_tok    <= n_res_tok;
        r_res_reg    <= n_res_reg;
        r_res_pend   <= n_res_pend;
        r_res_peak   <= n_res_peak;
        r_res_coal   <= n_res_coal;
        r_res_deliv  <= n_res_deliv;
    end

    // Slot memories. The link memory is only read where every followed link was written.
    always_ff @(posedge i_clk) begin
        r_node_q <= r_node_mem[rd_addr];
        r_tok_q  <= r_tok_mem[rd_addr];
        r_next_q <= r_next_mem[rd_addr];
        if (slot_we) begin
            r_node_mem[slot_wa] <= r_node;
            r_tok_mem[slot_wa]  <= r_tok;
        end
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
    end

    assign busy               = (r_state != S_IDLE);
    assign o_done             = r_done;
    assign o_result_code      = r_res_code;
    assign o_token_out        = r_res_tok;
    assign o_registered_count = r_res_reg;
    assign o_pending_count    = r_res_pend;
    assign o_max_pending      = r_res_peak;
    assign o_coalesced_count  = r_res_coal;
    assign o_delivered_count  = r_res_deliv;
    assign prdata             = (paddr[PADDR_W-1] == CFG_ENABLE) ? {31'd0, r_enable} : 32'd0;
    assign pready             = 1'b1;

    // Only occupied slots can be queued.
    a_pend_in_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & ~r_occ) == '0)
        else $error("pending mark on a free slot");

    // The pending counter tracks the pending marks.
    a_pend_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_pend) == int'(r_pend_cnt))
        else $error("pending count differs from pending marks");

    // The registered counter tracks the occupancy flags.
    a_reg_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_occ) == int'(r_reg_cnt))
        else $error("registered count differs from occupied slots");

    // The peak never falls below the current pending count.
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt <= r_peak)
        else $error("pending peak below pending count");

    // An accepted item always occupies the sequencer until its result is shown.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted item did not make the block busy");

endmodule
